>>> design/bet_pkg.sv
// ----------------------------------------------------------------------------
// Boolean expression tokenizer package
// Shared types and constants for the tokenizer, its register file and queue.
// ----------------------------------------------------------------------------
package bet_pkg;

  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned TOKQ_DEPTH = 8;
  localparam int unsigned TOKQ_PTR_W = 3;
  localparam int unsigned TOKQ_CNT_W = 4;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MARK         = 3'd0;
  localparam logic [2:0] REG_UNMARK       = 3'd1;
  localparam logic [2:0] REG_UNION_FIRST  = 3'd2;
  localparam logic [2:0] REG_UNION_SECOND = 3'd3;
  localparam logic [2:0] REG_INTER_FIRST  = 3'd4;
  localparam logic [2:0] REG_INTER_SECOND = 3'd5;
  localparam logic [2:0] REG_NEGATION     = 3'd6;
  localparam logic [2:0] REG_VARIABLE     = 3'd7;

  localparam logic [7:0] CHAR_TERM  = 8'd0;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;

  typedef enum logic [3:0] {
    KIND_MARK     = 4'd0,
    KIND_UNMARK   = 4'd1,
    KIND_UNION    = 4'd2,
    KIND_INTER    = 4'd3,
    KIND_NEG      = 4'd4,
    KIND_VAR      = 4'd5,
    KIND_END      = 4'd6,
    KIND_BAD_CHAR = 4'd7,
    KIND_BAD_PAIR = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_UNION2 = 3'd1,
    MODE_INTER2 = 3'd2,
    MODE_VAR    = 3'd3,
    MODE_DRAIN  = 3'd4
  } mode_e;

  typedef struct packed {
    logic [7:0] mark;
    logic [7:0] unmark;
    logic [7:0] union_first;
    logic [7:0] union_second;
    logic [7:0] inter_first;
    logic [7:0] inter_second;
    logic [7:0] negation;
    logic [7:0] variable;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic [POS_W-1:0]   pos;
    logic [IDX_W-1:0]   idx;
    logic               last;
  } token_t;

  // Tokens produced by one character: n is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] n;
    token_t     tok0;
    token_t     tok1;
  } push_t;

endpackage

>>> design/bet_if.sv
// ----------------------------------------------------------------------------
// Boolean expression tokenizer channels
// Valid/ready channels for source characters and for tokens.
// ----------------------------------------------------------------------------
interface bet_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface bet_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [11:0] token_pos;
  logic [15:0] var_index;
  logic        last;

  modport source (output valid, output token_kind, output token_pos,
                  output var_index, output last, input ready);
  modport sink (input valid, input token_kind, input token_pos,
                input var_index, input last, output ready);
endinterface

>>> design/boolean_expression_tokenizer.sv
// ----------------------------------------------------------------------------
// Boolean expression tokenizer
// Turns a stream of characters of a boolean set expression into tokens.
// ----------------------------------------------------------------------------
// The block takes one character per cycle on char_i while char_i.ready is
// high and returns tokens on token_o. A character is registered on
// acceptance, decoded against the scan state in the following cycle, and its
// tokens are written to an eight-entry token queue at the next edge. One
// character gives no token, one token or two; the token with last set is the
// final one for its character. The input sustains one character per cycle;
// the output hands out one token per cycle while token_o.ready is high, so a
// run of characters that each give two tokens is paced by the queue, which
// lowers ready while it holds more than four tokens. The eight character
// codes are written through the APB-style port at byte address four times
// the register number and must only be changed while the block is idle.
// MAX_LENGTH limits the reported character offset and INDEX_BITS the
// saturation point of variable indexes.
module boolean_expression_tokenizer import bet_pkg::*; #(
  parameter int unsigned MAX_LENGTH = 4096,
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  bet_char_if.sink          char_i,
  bet_token_if.source       token_o
);

  cfg_t                  cfg;
  push_t                 push;
  token_t                head;
  logic                  head_valid;
  logic [TOKQ_CNT_W-1:0] count;
  logic                  char_accept;

  bet_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // With at most four tokens queued there is room for both the character in
  // the input register and the one accepted now, two tokens each at worst.
  assign char_i.ready = (count <= TOKQ_CNT_W'(TOKQ_DEPTH - 4));
  assign char_accept  = char_i.valid && char_i.ready;

  bet_scan #(
    .MAX_LENGTH (MAX_LENGTH),
    .INDEX_BITS (INDEX_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_valid_i (char_accept),
    .char_i       (char_i.char_in),
    .cfg_i        (cfg),
    .push_o       (push)
  );

  bet_tok_fifo u_tok_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_i        (token_o.ready),
    .head_o       (head),
    .head_valid_o (head_valid),
    .count_o      (count)
  );

  assign token_o.valid      = head_valid;
  assign token_o.token_kind = head.kind;
  assign token_o.token_pos  = head.pos;
  assign token_o.var_index  = head.idx;
  assign token_o.last       = head.last;

endmodule

>>> design/bet_cfg_regs.sv
// ----------------------------------------------------------------------------
// Tokenizer configuration registers
// APB-style register file holding the eight character codes.
// ----------------------------------------------------------------------------
module bet_cfg_regs import bet_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic [2:0] reg_sel;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mark: 8'd40, unmark: 8'd41, union_first: 8'd124,
                 union_second: 8'd124, inter_first: 8'd38,
                 inter_second: 8'd38, negation: 8'd33, variable: 8'd120};
    end else if (wr_en) begin
      case (reg_sel)
        REG_MARK:         cfg_q.mark         <= pwdata[7:0];
        REG_UNMARK:       cfg_q.unmark       <= pwdata[7:0];
        REG_UNION_FIRST:  cfg_q.union_first  <= pwdata[7:0];
        REG_UNION_SECOND: cfg_q.union_second <= pwdata[7:0];
        REG_INTER_FIRST:  cfg_q.inter_first  <= pwdata[7:0];
        REG_INTER_SECOND: cfg_q.inter_second <= pwdata[7:0];
        REG_NEGATION:     cfg_q.negation     <= pwdata[7:0];
        REG_VARIABLE:     cfg_q.variable     <= pwdata[7:0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    case (reg_sel)
      REG_MARK:         prdata[7:0] = cfg_q.mark;
      REG_UNMARK:       prdata[7:0] = cfg_q.unmark;
      REG_UNION_FIRST:  prdata[7:0] = cfg_q.union_first;
      REG_UNION_SECOND: prdata[7:0] = cfg_q.union_second;
      REG_INTER_FIRST:  prdata[7:0] = cfg_q.inter_first;
      REG_INTER_SECOND: prdata[7:0] = cfg_q.inter_second;
      REG_NEGATION:     prdata[7:0] = cfg_q.negation;
      REG_VARIABLE:     prdata[7:0] = cfg_q.variable;
      default:          prdata      = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/bet_scan.sv
// ----------------------------------------------------------------------------
// Tokenizer scan stage
// Input register, scan state and the per-character token decision.
// ----------------------------------------------------------------------------
module bet_scan import bet_pkg::*; #(
  parameter int unsigned MAX_LENGTH = 4096,
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       char_valid_i,
  input  logic [7:0] char_i,
  input  cfg_t       cfg_i,
  output push_t      push_o
);

  localparam int unsigned PosMaxInt = (MAX_LENGTH < 4096) ? MAX_LENGTH - 1 : 4095;
  localparam logic [POS_W-1:0] PosMax = POS_W'(PosMaxInt);
  localparam logic [19:0] IdxMax =
    (INDEX_BITS < 16) ? 20'((64'd1 << INDEX_BITS) - 64'd1) : 20'd65535;

  logic             in_valid_q;
  logic [7:0]       in_char_q;
  mode_e            mode_q, mode_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] start_q, start_d;
  logic [IDX_W-1:0] acc_q, acc_d;

  // Start-of-token decode of the current character.
  logic       blank, is_digit;
  logic       bt_emit;
  kind_e      bt_kind;
  mode_e      bt_mode;
  logic       bt_clear_acc;
  logic [3:0] digit;
  logic [19:0] acc_next;
  token_t     var_tok, bt_tok;
  push_t      push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= char_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_valid_i) begin
      in_char_q <= char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_START;
      pos_q   <= '0;
      start_q <= '0;
      acc_q   <= '0;
    end else if (in_valid_q) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      acc_q   <= acc_d;
    end
  end

  assign blank    = (in_char_q == CHAR_SPACE) ||
                    ((in_char_q >= CHAR_TAB) && (in_char_q <= CHAR_CR));
  assign is_digit = (in_char_q >= CHAR_ZERO) && (in_char_q <= CHAR_NINE);
  assign digit    = 4'(in_char_q - CHAR_ZERO);
  assign acc_next = 20'({acc_q, 3'b000}) + 20'({acc_q, 1'b0}) + 20'(digit);

  // Priority follows the order of the character tests at token start.
  always_comb begin
    bt_emit      = 1'b0;
    bt_kind      = KIND_BAD_CHAR;
    bt_mode      = MODE_START;
    bt_clear_acc = 1'b0;
    if (in_char_q == cfg_i.mark) begin
      bt_emit = 1'b1;
      bt_kind = KIND_MARK;
    end else if (in_char_q == cfg_i.unmark) begin
      bt_emit = 1'b1;
      bt_kind = KIND_UNMARK;
    end else if (in_char_q == cfg_i.union_first) begin
      bt_mode = MODE_UNION2;
    end else if (in_char_q == cfg_i.inter_first) begin
      bt_mode = MODE_INTER2;
    end else if (in_char_q == cfg_i.negation) begin
      bt_emit = 1'b1;
      bt_kind = KIND_NEG;
    end else if (in_char_q == cfg_i.variable) begin
      bt_mode      = MODE_VAR;
      bt_clear_acc = 1'b1;
    end else begin
      bt_emit = 1'b1;
      bt_mode = MODE_DRAIN;
    end
  end

  assign var_tok = '{kind: KIND_VAR, pos: start_q, idx: acc_q, last: 1'b0};
  assign bt_tok  = '{kind: bt_kind, pos: pos_q, idx: '0, last: 1'b0};

  always_comb begin
    mode_d  = mode_q;
    start_d = start_q;
    acc_d   = acc_q;
    pos_d   = (pos_q < PosMax) ? pos_q + POS_W'(1) : pos_q;
    push    = '0;

    if (in_char_q == CHAR_TERM) begin
      // The terminator flushes any open token and then closes the string.
      mode_d  = MODE_START;
      pos_d   = '0;
      start_d = '0;
      acc_d   = '0;
      case (mode_q)
        MODE_VAR: begin
          push.n    = 2'd2;
          push.tok0 = var_tok;
          push.tok1 = '{kind: KIND_END, pos: pos_q, idx: '0, last: 1'b0};
        end
        MODE_UNION2, MODE_INTER2: begin
          push.n    = 2'd2;
          push.tok0 = '{kind: KIND_BAD_PAIR, pos: start_q, idx: '0, last: 1'b0};
          push.tok1 = '{kind: KIND_END, pos: pos_q, idx: '0, last: 1'b0};
        end
        default: begin
          push.n    = 2'd1;
          push.tok0 = '{kind: KIND_END, pos: pos_q, idx: '0, last: 1'b0};
        end
      endcase
    end else begin
      case (mode_q)
        MODE_UNION2, MODE_INTER2: begin
          push.n = 2'd1;
          if (in_char_q == ((mode_q == MODE_UNION2) ? cfg_i.union_second
                                                     : cfg_i.inter_second)) begin
            push.tok0 = '{kind: (mode_q == MODE_UNION2) ? KIND_UNION : KIND_INTER,
                          pos: start_q, idx: '0, last: 1'b0};
            mode_d    = MODE_START;
          end else begin
            push.tok0 = '{kind: KIND_BAD_PAIR, pos: start_q, idx: '0, last: 1'b0};
            mode_d    = MODE_DRAIN;
          end
        end
        MODE_VAR: begin
          if (is_digit) begin
            acc_d = (acc_next > IdxMax) ? IdxMax[IDX_W-1:0] : acc_next[IDX_W-1:0];
          end else begin
            // A non-blank character that ends the variable also opens the next token.
            push.tok0 = var_tok;
            acc_d     = '0;
            mode_d    = MODE_START;
            push.n    = 2'd1;
            if (!blank) begin
              start_d   = pos_q;
              mode_d    = bt_mode;
              push.tok1 = bt_tok;
              push.n    = bt_emit ? 2'd2 : 2'd1;
            end
          end
        end
        MODE_START: begin
          if (!blank) begin
            start_d   = pos_q;
            mode_d    = bt_mode;
            push.tok0 = bt_tok;
            push.n    = bt_emit ? 2'd1 : 2'd0;
            if (bt_clear_acc) begin
              acc_d = '0;
            end
          end
        end
        default: begin
          mode_d = MODE_DRAIN;
        end
      endcase
    end

    if (push.n == 2'd1) begin
      push.tok0.last = 1'b1;
    end else if (push.n == 2'd2) begin
      push.tok1.last = 1'b1;
    end

    if (!in_valid_q) begin
      push.n = 2'd0;
    end
  end

  assign push_o = push;

endmodule

>>> design/bet_tok_fifo.sv
// ----------------------------------------------------------------------------
// Token queue
// Small queue that takes up to two tokens a cycle and hands out one.
// ----------------------------------------------------------------------------
module bet_tok_fifo import bet_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  push_t                 push_i,
  input  logic                  pop_i,
  output token_t                head_o,
  output logic                  head_valid_o,
  output logic [TOKQ_CNT_W-1:0] count_o
);

  token_t                mem_q [TOKQ_DEPTH];
  logic [TOKQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [TOKQ_CNT_W-1:0] count_q;
  logic                  pop;
  logic [TOKQ_PTR_W-1:0] wr_ptr_b;

  assign pop      = pop_i && (count_q != '0);
  assign wr_ptr_b = wr_ptr_q + TOKQ_PTR_W'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.tok0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_b] <= push_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + TOKQ_PTR_W'(push_i.n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + TOKQ_PTR_W'(1);
      end
      count_q <= count_q + TOKQ_CNT_W'(push_i.n) - TOKQ_CNT_W'(pop);
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign head_valid_o = (count_q != '0);
  assign count_o      = count_q;

endmodule
